>>> sv/asc_pkg.sv
package asc_pkg;

  localparam int SampleBits = 12;
  localparam int CfgW       = 16;
  localparam int LevelW     = 32;
  localparam int DiffW      = ((SampleBits > CfgW) ? SampleBits : CfgW) + 2;
  localparam int MagW       = DiffW - 1 + CfgW;
  localparam int ValW       = MagW + 2;
  localparam int DeltaW     = LevelW + 2;
  localparam int CntW       = $clog2(MagW);

  typedef enum logic [2:0] {
    REG_IN_LOW    = 3'd0,
    REG_IN_HIGH   = 3'd1,
    REG_OUT_LOW   = 3'd2,
    REG_OUT_HIGH  = 3'd3,
    REG_CLAMP_EN  = 3'd4,
    REG_DEADBAND  = 3'd5,
    REG_THRESHOLD = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    CROSS_NONE = 2'd0,
    CROSS_HIGH = 2'd1,
    CROSS_LOW  = 2'd2
  } cross_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_LVL  = 5'b01000,
    ST_RPT  = 5'b10000
  } state_e;

endpackage

>>> sv/analog_sample_conditioner_top.sv
// A sample passes the states MUL, DIV, LVL and RPT; when either span is zero (no mapping)
// the DIV state is skipped and the raw sample is passed through as the level.
// A new sample is accepted only in IDLE, after the previous one has left RPT. The
// 33-step restoring divider resolves one quotient bit per cycle.
// A result waits in the output register; the next sample is taken meanwhile.
// Reset (rst_ni low, asynchronous) clears the configuration, the report history,
// the result register and the sequencer.
module analog_sample_conditioner_top import asc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [CfgW-1:0]       cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SampleBits-1:0] raw_sample_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  reported_o,
  output logic [LevelW-1:0]     level_o,
  output logic                  above_threshold_o,
  output logic [1:0]            crossing_o
);

  logic signed [CfgW-1:0] in_low_q, in_high_q, out_low_q, out_high_q, threshold_q;
  logic                   clamp_en_q;
  logic [CfgW-1:0]        deadband_q;

  state_e                  state_q, state_d;
  logic [SampleBits-1:0]   raw_q;
  logic [MagW-1:0]         quo_q, quo_d;
  logic [CfgW-1:0]         rem_q, rem_d;
  logic [CfgW-1:0]         div_q;
  logic                    neg_q;
  logic                    bypass_q;
  logic [CntW-1:0]         cnt_q;
  logic signed [LevelW-1:0] level_q;

  logic signed [LevelW-1:0] last_rep_q;
  logic                    have_rep_q, last_side_q, have_side_q;

  logic                    out_valid_q, reported_q, above_q;
  logic [LevelW-1:0]       level_out_q;
  cross_e                  crossing_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_low_q    <= '0;
      in_high_q   <= '0;
      out_low_q   <= '0;
      out_high_q  <= '0;
      clamp_en_q  <= 1'b0;
      deadband_q  <= '0;
      threshold_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_IN_LOW:    in_low_q    <= cfg_wdata_i;
        REG_IN_HIGH:   in_high_q   <= cfg_wdata_i;
        REG_OUT_LOW:   out_low_q   <= cfg_wdata_i;
        REG_OUT_HIGH:  out_high_q  <= cfg_wdata_i;
        REG_CLAMP_EN:  clamp_en_q  <= cfg_wdata_i[0];
        REG_DEADBAND:  deadband_q  <= cfg_wdata_i;
        REG_THRESHOLD: threshold_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // spans and product
  logic signed [DiffW-1:0] raw_ext, diff;
  logic [DiffW-2:0]        diff_mag;
  logic signed [CfgW:0]    in_span, out_span;
  logic [CfgW-1:0]         is_mag, os_mag;
  logic                    span_zero;

  always_comb begin
    raw_ext  = signed'({{(DiffW-SampleBits){1'b0}}, raw_q});
    diff     = raw_ext - DiffW'(in_low_q);
    diff_mag = diff[DiffW-1] ? (DiffW-1)'(-diff) : diff[DiffW-2:0];
    in_span  = (CfgW+1)'(in_high_q) - (CfgW+1)'(in_low_q);
    out_span = (CfgW+1)'(out_high_q) - (CfgW+1)'(out_low_q);
    is_mag   = in_span[CfgW] ? CfgW'(-in_span) : in_span[CfgW-1:0];
    os_mag   = out_span[CfgW] ? CfgW'(-out_span) : out_span[CfgW-1:0];
    span_zero = (in_span == '0) || (out_span == '0);
  end

  // one restoring step
  logic [CfgW:0] trial;
  logic          fits;
  always_comb begin
    trial = {rem_q, quo_q[MagW-1]} - {1'b0, div_q};
    fits  = !trial[CfgW] || rem_q[CfgW-1];
    rem_d = fits ? trial[CfgW-1:0] : {rem_q[CfgW-2:0], quo_q[MagW-1]};
    quo_d = {quo_q[MagW-2:0], fits};
  end

  // signed quotient, offset, clamp, saturate, bypass select
  logic signed [ValW-1:0] qs, v, lo_ext, hi_ext, lvl_full;
  logic signed [LevelW-1:0] lvl_d;
  localparam logic signed [ValW-1:0] LvlMax = ValW'(2**(LevelW-1) - 1);
  localparam logic signed [ValW-1:0] LvlMin = -(ValW'(2**(LevelW-1) - 1)) - ValW'(1);

  always_comb begin
    qs     = neg_q ? -signed'({2'b00, quo_q}) : signed'({2'b00, quo_q});
    v      = qs + ValW'(out_low_q);
    lo_ext = (out_low_q < out_high_q) ? ValW'(out_low_q) : ValW'(out_high_q);
    hi_ext = (out_low_q < out_high_q) ? ValW'(out_high_q) : ValW'(out_low_q);
    lvl_full = v;
    if (clamp_en_q) begin
      if (lvl_full < lo_ext) lvl_full = lo_ext;
      if (lvl_full > hi_ext) lvl_full = hi_ext;
    end
    if (lvl_full > LvlMax) lvl_full = LvlMax;
    if (lvl_full < LvlMin) lvl_full = LvlMin;
    lvl_d = bypass_q ? signed'({{(LevelW-SampleBits){1'b0}}, raw_q}) : lvl_full[LevelW-1:0];
  end

  // deadband and threshold
  logic signed [DeltaW-1:0] delta, ndelta, db_ext;
  logic                     rep, side;
  always_comb begin
    delta  = DeltaW'(level_q) - DeltaW'(last_rep_q);
    ndelta = -delta;
    db_ext = signed'({{(DeltaW-CfgW){1'b0}}, deadband_q});
    rep    = !have_rep_q || (delta >= db_ext) || (ndelta >= db_ext);
    side   = level_q >= LevelW'(threshold_q);
  end

  logic out_free;
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_MUL;
      ST_MUL:  state_d = span_zero ? ST_LVL : ST_DIV;
      ST_DIV:  if (cnt_q == '0) state_d = ST_LVL;
      ST_LVL:  state_d = ST_RPT;
      ST_RPT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_MUL) cnt_q <= CntW'(MagW - 1);
      else if (state_q == ST_DIV) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (in_valid_i) raw_q <= raw_sample_i;
      ST_MUL: begin
        quo_q    <= MagW'(diff_mag) * MagW'(os_mag);
        rem_q    <= '0;
        div_q    <= is_mag;
        neg_q    <= diff[DiffW-1] ^ out_span[CfgW] ^ in_span[CfgW];
        bypass_q <= span_zero;
      end
      ST_DIV: begin
        quo_q <= quo_d;
        rem_q <= rem_d;
      end
      ST_LVL:  level_q <= lvl_d;
      default: ;
    endcase
  end

  // history and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_rep_q  <= '0;
      have_rep_q  <= 1'b0;
      last_side_q <= 1'b0;
      have_side_q <= 1'b0;
      out_valid_q <= 1'b0;
      reported_q  <= 1'b0;
      above_q     <= 1'b0;
      level_out_q <= '0;
      crossing_q  <= CROSS_NONE;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if ((state_q == ST_RPT) && out_free) begin
        out_valid_q <= 1'b1;
        reported_q  <= rep;
        above_q     <= side;
        level_out_q <= level_q;
        crossing_q  <= CROSS_NONE;
        if (rep) begin
          last_rep_q <= level_q;
          have_rep_q <= 1'b1;
          if (!have_side_q || (side != last_side_q)) begin
            crossing_q  <= side ? CROSS_HIGH : CROSS_LOW;
            last_side_q <= side;
            have_side_q <= 1'b1;
          end
        end
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign reported_o        = reported_q;
  assign level_o           = level_out_q;
  assign above_threshold_o = above_q;
  assign crossing_o        = crossing_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < div_q)) else $error("divider remainder out of range");

  a_cross_needs_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (crossing_o != CROSS_NONE)) |-> reported_o)
    else $error("crossing without report");

  a_cross_matches_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (crossing_o == CROSS_HIGH)) |-> above_threshold_o)
    else $error("rising crossing on low level");

  a_history_after_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) && reported_q |-> have_rep_q && have_side_q && (last_rep_q == level_q))
    else $error("report history not updated");

endmodule
